[rtl/core/mbs_pkg.sv]
// Shared constants and types of the Modbus TCP register server.
`timescale 1ns / 1ps

package mbs_pkg;

  // Default build options.
  localparam int NUM_REGS_DEF   = 16;
  localparam int DIST_INDEX_DEF = 0;

  // Reset value of the distance register.
  localparam logic [15:0] DIST_RESET = 16'd1000;

  // Header and request limits.
  localparam logic [7:0]  LEN_MIN       = 8'd2;
  localparam logic [7:0]  LEN_MAX       = 8'd253;
  localparam logic [7:0]  LEN_FULL_REQ  = 8'd6;
  localparam logic [15:0] READ_CNT_MAX  = 16'd125;
  localparam int          HDR_BYTES     = 6;
  localparam int          BODY_KEEP     = 6;

  // Input operations.
  localparam logic OP_LINK = 1'b0;
  localparam logic OP_HOST = 1'b1;

  // Function codes and exception codes.
  localparam logic [7:0] FC_READ_HOLD  = 8'h03;
  localparam logic [7:0] FC_WRITE_ONE  = 8'h06;
  localparam logic [7:0] FC_EXC_FLAG   = 8'h80;
  localparam logic [7:0] EXC_BAD_FUNC  = 8'h01;
  localparam logic [7:0] EXC_BAD_ADDR  = 8'h02;
  localparam logic [7:0] EXC_BAD_VALUE = 8'h03;

  // Byte positions within a reply frame.
  localparam logic [5:0] POS_TID_HI  = 6'd0;
  localparam logic [5:0] POS_TID_LO  = 6'd1;
  localparam logic [5:0] POS_PID_HI  = 6'd2;
  localparam logic [5:0] POS_PID_LO  = 6'd3;
  localparam logic [5:0] POS_LEN_HI  = 6'd4;
  localparam logic [5:0] POS_LEN_LO  = 6'd5;
  localparam logic [5:0] POS_UNIT    = 6'd6;
  localparam logic [5:0] POS_PDU0    = 6'd7;
  localparam logic [5:0] POS_PDU1    = 6'd8;
  localparam logic [5:0] POS_PDU2    = 6'd9;
  localparam logic [5:0] POS_PDU3    = 6'd10;
  localparam logic [7:0] HDR_AND_UNIT = 8'd6;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DECIDE = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } reply_mode_t;

endpackage

[rtl/core/modbus_tcp_register_server.sv]
// Modbus TCP holding-register server for one connection (functions 03 and 06).
`timescale 1ns / 1ps

// Each accepted item is one received link byte (in_op = 0) or one local
// register write (in_op = 1). The byte that completes a request body moves
// the sequencer to a decode state, and then any reply streams out one byte
// per cycle while out_ready stays high, through a one-entry output register;
// a reply has 7 + PDU length bytes. A single byte selector walks the reply
// positions and the register file under a three-state sequencer; in_ready
// is low from the decode state until the final reply byte has been loaded
// into the output register.
module modbus_tcp_register_server #(
  parameter int NUM_REGS   = mbs_pkg::NUM_REGS_DEF,
  parameter int DIST_INDEX = mbs_pkg::DIST_INDEX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_rx_byte,
  input  logic [3:0]  in_host_index,
  input  logic [15:0] in_host_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tx_byte,
  output logic        out_last
);

  localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int DIST_POS = DIST_INDEX % NUM_REGS;

  mbs_pkg::state_t      state_r, state_nxt;
  mbs_pkg::reply_mode_t mode_r, mode_nxt;

  logic [7:0]  hw_r [mbs_pkg::HDR_BYTES];
  logic [7:0]  bb_r [mbs_pkg::BODY_KEEP];
  logic [15:0] regs_r [NUM_REGS];

  logic [2:0]       fill_r, fill_nxt;
  logic             in_body_r, in_body_nxt;
  logic [7:0]       body_rem_r, body_rem_nxt;
  logic [2:0]       body_pos_r, body_pos_nxt;
  logic [7:0]       plen_r, plen_nxt;
  logic [7:0]       pdu0_r, pdu0_nxt;
  logic [7:0]       pdu1_r, pdu1_nxt;
  logic [5:0]       k_r, k_nxt;
  logic [5:0]       last_idx_r, last_idx_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic             hi_r, hi_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;

  logic        accept;
  logic        link_acc;
  logic        host_acc;
  logic        hdr_bad;
  logic        hdr_done;
  logic        body_end;
  logic        emit_go;
  logic [7:0]  fc;
  logic [15:0] addr;
  logic [15:0] cnt;
  logic [16:0] span;
  logic        reg_wr;
  logic [7:0]  plen_calc;
  logic [7:0]  emit_byte;

  assign accept   = in_valid && in_ready;
  assign link_acc = accept && (in_op == mbs_pkg::OP_LINK);
  assign host_acc = accept && (in_op == mbs_pkg::OP_HOST);

  // The header check sees the five held bytes plus the incoming one.
  assign hdr_done = link_acc && !in_body_r && (fill_r == 3'd5);
  assign hdr_bad  = (hw_r[2] != 8'h00) || (hw_r[3] != 8'h00) || (hw_r[4] != 8'h00) ||
                    (in_rx_byte < mbs_pkg::LEN_MIN) || (in_rx_byte > mbs_pkg::LEN_MAX);
  assign body_end = link_acc && in_body_r && (body_rem_r == 8'd1);

  assign fc   = bb_r[1];
  assign addr = {bb_r[2], bb_r[3]};
  assign cnt  = {bb_r[4], bb_r[5]};
  assign span = {1'b0, addr} + {1'b0, cnt};

  assign emit_go = (state_r == mbs_pkg::ST_EMIT) && (!out_valid_r || out_ready);

  // Reply byte selector.
  always_comb begin
    case (k_r)
      mbs_pkg::POS_TID_HI: emit_byte = hw_r[0];
      mbs_pkg::POS_TID_LO: emit_byte = hw_r[1];
      mbs_pkg::POS_PID_HI,
      mbs_pkg::POS_PID_LO,
      mbs_pkg::POS_LEN_HI: emit_byte = 8'h00;
      mbs_pkg::POS_LEN_LO: emit_byte = plen_r + 8'd1;
      mbs_pkg::POS_UNIT:   emit_byte = bb_r[0];
      mbs_pkg::POS_PDU0:   emit_byte = pdu0_r;
      mbs_pkg::POS_PDU1:   emit_byte = pdu1_r;
      default: begin
        if (mode_r == mbs_pkg::MODE_WRITE) begin
          if (k_r == mbs_pkg::POS_PDU2) begin
            emit_byte = bb_r[3];
          end else if (k_r == mbs_pkg::POS_PDU3) begin
            emit_byte = bb_r[4];
          end else begin
            emit_byte = bb_r[5];
          end
        end else begin
          emit_byte = hi_r ? regs_r[ptr_r][15:8] : regs_r[ptr_r][7:0];
        end
      end
    endcase
  end

  // Sequencer and request decode.
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    fill_nxt      = fill_r;
    in_body_nxt   = in_body_r;
    body_rem_nxt  = body_rem_r;
    body_pos_nxt  = body_pos_r;
    plen_nxt      = plen_r;
    pdu0_nxt      = pdu0_r;
    pdu1_nxt      = pdu1_r;
    k_nxt         = k_r;
    last_idx_nxt  = last_idx_r;
    ptr_nxt       = ptr_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    reg_wr        = 1'b0;
    plen_calc     = 8'd2;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      mbs_pkg::ST_IDLE: begin
        if (link_acc) begin
          if (in_body_r) begin
            body_rem_nxt = body_rem_r - 8'd1;
            if (body_pos_r < 3'(mbs_pkg::BODY_KEEP)) begin
              body_pos_nxt = body_pos_r + 3'd1;
            end
            if (body_end) begin
              in_body_nxt = 1'b0;
              fill_nxt    = 3'd0;
              state_nxt   = mbs_pkg::ST_DECIDE;
            end
          end else if (hdr_done) begin
            if (!hdr_bad) begin
              in_body_nxt  = 1'b1;
              body_rem_nxt = in_rx_byte;
              body_pos_nxt = 3'd0;
              fill_nxt     = 3'd6;
            end
          end else begin
            fill_nxt = fill_r + 3'd1;
          end
        end
      end

      mbs_pkg::ST_DECIDE: begin
        mode_nxt  = mbs_pkg::MODE_PLAIN;
        k_nxt     = 6'd0;
        hi_nxt    = 1'b1;
        ptr_nxt   = addr[IDX_W-1:0];
        state_nxt = mbs_pkg::ST_EMIT;
        if (fc == mbs_pkg::FC_READ_HOLD) begin
          if (hw_r[5] < mbs_pkg::LEN_FULL_REQ) begin
            state_nxt = mbs_pkg::ST_IDLE;
          end else if ((cnt == 16'd0) || (cnt > mbs_pkg::READ_CNT_MAX)) begin
            pdu0_nxt = fc | mbs_pkg::FC_EXC_FLAG;
            pdu1_nxt = mbs_pkg::EXC_BAD_VALUE;
          end else if (span > 17'(NUM_REGS)) begin
            pdu0_nxt = fc | mbs_pkg::FC_EXC_FLAG;
            pdu1_nxt = mbs_pkg::EXC_BAD_ADDR;
          end else begin
            mode_nxt  = mbs_pkg::MODE_READ;
            pdu0_nxt  = mbs_pkg::FC_READ_HOLD;
            pdu1_nxt  = {cnt[6:0], 1'b0};
            plen_calc = 8'd2 + {cnt[6:0], 1'b0};
          end
        end else if (fc == mbs_pkg::FC_WRITE_ONE) begin
          if (hw_r[5] < mbs_pkg::LEN_FULL_REQ) begin
            state_nxt = mbs_pkg::ST_IDLE;
          end else if (addr >= 16'(NUM_REGS)) begin
            pdu0_nxt = fc | mbs_pkg::FC_EXC_FLAG;
            pdu1_nxt = mbs_pkg::EXC_BAD_ADDR;
          end else begin
            reg_wr    = 1'b1;
            mode_nxt  = mbs_pkg::MODE_WRITE;
            pdu0_nxt  = mbs_pkg::FC_WRITE_ONE;
            pdu1_nxt  = bb_r[2];
            plen_calc = 8'd5;
          end
        end else begin
          pdu0_nxt = fc | mbs_pkg::FC_EXC_FLAG;
          pdu1_nxt = mbs_pkg::EXC_BAD_FUNC;
        end
        plen_nxt     = plen_calc;
        last_idx_nxt = 6'(mbs_pkg::HDR_AND_UNIT + plen_calc);
      end

      mbs_pkg::ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = emit_byte;
          out_last_nxt  = (k_r == last_idx_r);
          k_nxt         = k_r + 6'd1;
          if (k_r >= mbs_pkg::POS_PDU2) begin
            hi_nxt = !hi_r;
            if (!hi_r) begin
              ptr_nxt = ptr_r + IDX_W'(1);
            end
          end
          if (k_r == last_idx_r) begin
            state_nxt = mbs_pkg::ST_IDLE;
          end
        end
      end

      default: state_nxt = mbs_pkg::ST_IDLE;
    endcase
  end

  // Control state and the holding registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbs_pkg::ST_IDLE;
      fill_r      <= 3'd0;
      in_body_r   <= 1'b0;
      body_rem_r  <= 8'd0;
      body_pos_r  <= 3'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= (i == DIST_POS) ? mbs_pkg::DIST_RESET : 16'd0;
      end
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      in_body_r   <= in_body_nxt;
      body_rem_r  <= body_rem_nxt;
      body_pos_r  <= body_pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (host_acc && ({1'b0, in_host_index} < 5'(NUM_REGS))) begin
        regs_r[in_host_index[IDX_W-1:0]] <= in_host_value;
      end else if (reg_wr) begin
        regs_r[addr[IDX_W-1:0]] <= cnt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    plen_r     <= plen_nxt;
    pdu0_r     <= pdu0_nxt;
    pdu1_r     <= pdu1_nxt;
    k_r        <= k_nxt;
    last_idx_r <= last_idx_nxt;
    ptr_r      <= ptr_nxt;
    hi_r       <= hi_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    if (link_acc && !in_body_r) begin
      if (!hdr_done) begin
        hw_r[fill_r] <= in_rx_byte;
      end else if (hdr_bad) begin
        // Drop the oldest byte and keep waiting for a valid header.
        for (int i = 0; i < 4; i++) begin
          hw_r[i] <= hw_r[i+1];
        end
        hw_r[4] <= in_rx_byte;
      end else begin
        hw_r[5] <= in_rx_byte;
      end
    end
    if (link_acc && in_body_r && (body_pos_r < 3'(mbs_pkg::BODY_KEEP))) begin
      bb_r[body_pos_r] <= in_rx_byte;
    end
  end

  assign in_ready    = (state_r == mbs_pkg::ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_tx_byte = out_byte_r;
  assign out_last    = out_last_r;

endmodule

[rtl/core/mbs_checker.sv]
// Port-level checker for the Modbus TCP register server, bound to the top level.
`timescale 1ns / 1ps

module mbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_tx_byte,
  input logic        out_last
);

  // A reply held back by the sink stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tx_byte) && $stable(out_last))
    else $error("reply transaction changed while stalled");

  // No reply byte is pending right after reset.
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("reply transaction present after reset");

  // Input is not taken while a reply frame is only partly delivered.
  a_busy_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready in the middle of a reply frame");

  // Reply bytes of one frame follow each other without gaps.
  a_frame_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a reply frame");

endmodule

bind modbus_tcp_register_server mbs_checker u_mbs_checker (.*);

[test/modbus_tcp_register_server_tb.sv]
// Self-checking testbench for the Modbus TCP holding-register server.
`timescale 1ns / 1ps

module modbus_tcp_register_server_tb;

  localparam int NREGS       = mbs_pkg::NUM_REGS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic        op;
    logic [7:0]  rx;
    logic [3:0]  idx;
    logic [15:0] val;
  } req_item_t;

  typedef struct packed {
    logic [7:0] tx;
    logic       is_last;
  } reply_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_op = mbs_pkg::OP_LINK;
  logic [7:0]  in_rx_byte = '0;
  logic [3:0]  in_host_index = '0;
  logic [15:0] in_host_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_tx_byte;
  logic        out_last;

  modbus_tcp_register_server u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_rx_byte   (in_rx_byte),
    .in_host_index(in_host_index),
    .in_host_value(in_host_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_tx_byte  (out_tx_byte),
    .out_last     (out_last)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Stimulus and expected reply bytes.
  req_item_t   pending_q[$];
  reply_byte_t reply_q[$];
  req_item_t   offer;
  int          pushed = 0;
  int          mismatches = 0;
  int          cycles = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_left = 0;
  logic        hold_kick = 1'b0;

  // Shadow copy of the server state.
  logic [7:0]  hdr_win[6];
  int          hdr_fill;
  logic [7:0]  body_keep[6];
  logic [7:0]  body_left;
  logic        in_frame_body;
  logic [15:0] regs[NREGS];

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch at cycle %0d: %s got %02h want %02h", cycles, what, got, want);
    mismatches++;
  endtask

  // Forms the reply that a completed request body causes.
  task automatic build_reply();
    logic [15:0] lenf;
    logic [15:0] addr;
    logic [15:0] cnt;
    logic [16:0] span;
    logic [7:0]  fc;
    logic [7:0]  pdu[$];
    logic [7:0]  frame[$];
    reply_byte_t rb;
    int          i;
    lenf = {hdr_win[4], hdr_win[5]};
    fc   = body_keep[1];
    addr = {body_keep[2], body_keep[3]};
    cnt  = {body_keep[4], body_keep[5]};
    span = {1'b0, addr} + {1'b0, cnt};
    if (fc == mbs_pkg::FC_READ_HOLD) begin
      if (lenf < mbs_pkg::LEN_FULL_REQ) return;
      if (cnt == 0 || cnt > mbs_pkg::READ_CNT_MAX) begin
        pdu = '{mbs_pkg::FC_READ_HOLD | mbs_pkg::FC_EXC_FLAG, mbs_pkg::EXC_BAD_VALUE};
      end else if (span > NREGS) begin
        pdu = '{mbs_pkg::FC_READ_HOLD | mbs_pkg::FC_EXC_FLAG, mbs_pkg::EXC_BAD_ADDR};
      end else begin
        pdu = '{mbs_pkg::FC_READ_HOLD, {cnt[6:0], 1'b0}};
        for (i = 0; i < cnt; i++) begin
          pdu.insert(pdu.size(), regs[addr + i][15:8]);
          pdu.insert(pdu.size(), regs[addr + i][7:0]);
        end
      end
    end else if (fc == mbs_pkg::FC_WRITE_ONE) begin
      if (lenf < mbs_pkg::LEN_FULL_REQ) return;
      if (addr >= NREGS) begin
        pdu = '{mbs_pkg::FC_WRITE_ONE | mbs_pkg::FC_EXC_FLAG, mbs_pkg::EXC_BAD_ADDR};
      end else begin
        regs[addr] = cnt;
        pdu = '{mbs_pkg::FC_WRITE_ONE, body_keep[2], body_keep[3], body_keep[4],
                body_keep[5]};
      end
    end else begin
      pdu = '{fc | mbs_pkg::FC_EXC_FLAG, mbs_pkg::EXC_BAD_FUNC};
    end
    frame = '{hdr_win[0], hdr_win[1], 8'h00, 8'h00, 8'h00, 8'(pdu.size() + 1), body_keep[0]};
    foreach (pdu[k]) frame.insert(frame.size(), pdu[k]);
    foreach (frame[k]) begin
      rb.tx      = frame[k];
      rb.is_last = (k == frame.size() - 1);
      reply_q.insert(reply_q.size(), rb);
    end
  endtask

  // Advances the shadow state by one accepted transaction.
  task automatic serve_item(req_item_t it);
    logic [15:0] lenf;
    logic [15:0] pid;
    logic [7:0]  pos;
    if (it.op == mbs_pkg::OP_HOST) begin
      if (it.idx < NREGS) regs[it.idx] = it.val;
    end else if (in_frame_body) begin
      lenf = {hdr_win[4], hdr_win[5]};
      pos  = lenf[7:0] - body_left;
      if (pos < mbs_pkg::BODY_KEEP) body_keep[pos] = it.rx;
      body_left = body_left - 8'd1;
      if (body_left == 0) begin
        in_frame_body = 1'b0;
        hdr_fill = 0;
        build_reply();
      end
    end else begin
      if (hdr_fill > 5) hdr_fill = 5;
      hdr_win[hdr_fill] = it.rx;
      hdr_fill++;
      if (hdr_fill == mbs_pkg::HDR_BYTES) begin
        pid  = {hdr_win[2], hdr_win[3]};
        lenf = {hdr_win[4], hdr_win[5]};
        if (pid != 0 || lenf < mbs_pkg::LEN_MIN || lenf > mbs_pkg::LEN_MAX) begin
          // Resynchronize: drop the oldest byte and wait for one more.
          for (int k = 0; k < 5; k++) hdr_win[k] = hdr_win[k + 1];
          hdr_fill = 5;
        end else begin
          in_frame_body = 1'b1;
          body_left = lenf[7:0];
        end
      end
    end
  endtask

  task automatic push_item(logic op, logic [7:0] rx, logic [3:0] idx, logic [15:0] val);
    req_item_t it;
    it.op  = op;
    it.rx  = rx;
    it.idx = idx;
    it.val = val;
    pending_q.insert(pending_q.size(), it);
    pushed++;
  endtask

  task automatic push_link(logic [7:0] b);
    push_item(mbs_pkg::OP_LINK, b, 4'($urandom_range(15)), 16'($urandom_range(65535)));
  endtask

  task automatic push_host(logic [3:0] idx, logic [15:0] val);
    push_item(mbs_pkg::OP_HOST, 8'($urandom_range(255)), idx, val);
  endtask

  // One request frame; bodies shorter than six bytes are cut, longer ones padded.
  task automatic push_frame(logic [15:0] tid, logic [7:0] lenf, logic [7:0] fc,
                            logic [15:0] addr, logic [15:0] cnt, bit mix_host);
    logic [7:0] raw[$];
    logic [7:0] body[6];
    body = '{8'($urandom_range(255)), fc, addr[15:8], addr[7:0], cnt[15:8], cnt[7:0]};
    raw = '{tid[15:8], tid[7:0], 8'h00, 8'h00, 8'h00, lenf};
    for (int i = 0; i < lenf; i++)
      raw.insert(raw.size(), i < mbs_pkg::BODY_KEEP ? body[i] : 8'($urandom_range(255)));
    foreach (raw[k]) begin
      if (mix_host && $urandom_range(15) == 0)
        push_host(4'($urandom_range(15)), 16'($urandom_range(65535)));
      push_link(raw[k]);
    end
  endtask

  task automatic push_random_step();
    logic [15:0] tid;
    logic [15:0] a;
    logic [15:0] c;
    logic [7:0]  lenf;
    logic [7:0]  fc;
    int          kind;
    tid  = 16'($urandom_range(65535));
    lenf = ($urandom_range(5) == 0) ? 8'($urandom_range(7, 20)) : mbs_pkg::LEN_FULL_REQ;
    kind = $urandom_range(11);
    case (kind)
      0, 1, 2: begin
        a = 16'($urandom_range(NREGS - 1));
        c = 16'($urandom_range(1, NREGS - a));
        push_frame(tid, lenf, mbs_pkg::FC_READ_HOLD, a, c, 1'b1);
      end
      3: begin
        c = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(126, 65535));
        push_frame(tid, lenf, mbs_pkg::FC_READ_HOLD, 16'($urandom_range(65535)), c, 1'b1);
      end
      4: begin
        a = 16'($urandom_range(65535));
        c = 16'($urandom_range(1, mbs_pkg::READ_CNT_MAX));
        if ({1'b0, a} + {1'b0, c} <= NREGS) a = 16'(NREGS);
        push_frame(tid, lenf, mbs_pkg::FC_READ_HOLD, a, c, 1'b1);
      end
      5, 6: begin
        push_frame(tid, lenf, mbs_pkg::FC_WRITE_ONE, 16'($urandom_range(NREGS - 1)),
                   16'($urandom_range(65535)), 1'b1);
      end
      7: begin
        push_frame(tid, lenf, mbs_pkg::FC_WRITE_ONE, 16'($urandom_range(NREGS, 65535)),
                   16'($urandom_range(65535)), 1'b1);
      end
      8: begin
        do fc = 8'($urandom_range(255));
        while (fc == mbs_pkg::FC_READ_HOLD || fc == mbs_pkg::FC_WRITE_ONE);
        push_frame(tid, 8'($urandom_range(mbs_pkg::LEN_MIN, 8)), fc,
                   16'($urandom_range(65535)), 16'($urandom_range(65535)), 1'b1);
      end
      9: begin
        fc = ($urandom_range(1) == 0) ? mbs_pkg::FC_READ_HOLD : mbs_pkg::FC_WRITE_ONE;
        push_frame(tid, 8'($urandom_range(mbs_pkg::LEN_MIN, mbs_pkg::LEN_FULL_REQ - 1)), fc,
                   16'($urandom_range(65535)), 16'($urandom_range(65535)), 1'b1);
      end
      10: begin
        // Line noise, mostly nonzero so that the header window resyncs quickly.
        repeat ($urandom_range(1, 8))
          push_link(($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                             : 8'($urandom_range(1, 255)));
      end
      default: begin
        repeat ($urandom_range(1, 3))
          push_host(4'($urandom_range(15)), 16'($urandom_range(65535)));
      end
    endcase
  endtask

  task automatic push_random(int budget);
    int start;
    start = pushed;
    while (pushed - start < budget) push_random_step();
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_valid || reply_q.size() != 0) @(posedge clk);
  endtask

  // Driver: offers the pending transactions and tracks each acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) serve_item(offer);
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          offer = pending_q.pop_front();
          in_valid      <= 1'b1;
          in_op         <= offer.op;
          in_rx_byte    <= offer.rx;
          in_host_index <= offer.idx;
          in_host_value <= offer.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started by the stimulus process.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each reply byte against the oldest expectation.
  always @(posedge clk) begin
    reply_byte_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          report_mismatch("unexpected reply byte", out_tx_byte, 8'h00);
        end else begin
          want = reply_q.pop_front();
          if (out_tx_byte !== want.tx) report_mismatch("tx_byte", out_tx_byte, want.tx);
          if (out_last !== want.is_last)
            report_mismatch("last", 8'(out_last), 8'(want.is_last));
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("modbus_tcp_register_server test failed");
      $finish;
    end
  end

  initial begin
    foreach (hdr_win[k]) hdr_win[k] = '0;
    foreach (body_keep[k]) body_keep[k] = '0;
    foreach (regs[k]) regs[k] = '0;
    regs[mbs_pkg::DIST_INDEX_DEF % NREGS] = mbs_pkg::DIST_RESET;
    hdr_fill = 0;
    body_left = '0;
    in_frame_body = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: top register, a rejected header with length 254, a full read of
    // the whole register file, and a write to the highest possible address.
    push_host(4'd15, 16'hFFFF);
    push_link(8'h55); push_link(8'hAA); push_link(8'h00);
    push_link(8'h00); push_link(8'h00); push_link(8'hFE);
    push_frame(16'h1234, mbs_pkg::LEN_FULL_REQ, mbs_pkg::FC_READ_HOLD, 16'd0, 16'(NREGS),
               1'b0);
    push_frame(16'hFFFF, mbs_pkg::LEN_FULL_REQ, mbs_pkg::FC_WRITE_ONE, 16'hFFFF, 16'h0000,
               1'b0);
    drain();

    // Receiver holds off while requests keep coming, so the input stalls.
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    repeat (2) push_frame(16'($urandom_range(65535)), mbs_pkg::LEN_FULL_REQ,
                          mbs_pkg::FC_READ_HOLD, 16'd0, 16'($urandom_range(1, NREGS)), 1'b0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  <= (ph == 1) ? 52 : (ph == 3) ? 10 : 0;
      rx_stall_pct <= (ph == 2) ? 52 : (ph == 3) ? 10 : 0;
      @(posedge clk);
      push_random(9);
      drain();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("modbus_tcp_register_server test passed");
    end else begin
      $display("modbus_tcp_register_server test failed");
    end
    $finish;
  end

endmodule
